FILE: hdl/met_pkg.sv
// Shared types and constants for the multichannel extremum tracker.
`timescale 1ns / 1ps
`default_nettype none

package met_pkg;

    // Result kind codes
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_MAX  = 2'd1;
    localparam logic [1:0] KIND_MIN  = 2'd2;

    // Ring slot pointer width, sized for the deepest ring store
    localparam int SLOT_PTR_W = 10;

    // Saturation limits
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
    localparam logic [47:0] SUM_MAX   = 48'hFFFF_FFFF_FFFF;

    // Per-channel tracking state, one word of the state memory
    typedef struct packed {
        logic [31:0]           prev_sample;
        logic [31:0]           older_sample;
        logic [31:0]           max_count;
        logic [31:0]           min_count;
        logic [47:0]           max_interval_sum;
        logic [47:0]           min_interval_sum;
        logic [31:0]           last_max_time;
        logic [31:0]           last_min_time;
        logic [SLOT_PTR_W-1:0] max_slot;
        logic [SLOT_PTR_W-1:0] min_slot;
    } chan_state_t;

    // Result of examining one channel history
    typedef struct packed {
        logic [1:0]            kind;
        logic [31:0]           extreme_value;
        logic [SLOT_PTR_W-1:0] slot_ptr;
        logic [31:0]           interval;
        logic [31:0]           kind_count;
        logic [47:0]           interval_sum;
    } ext_result_t;

endpackage

`default_nettype wire

FILE: hdl/met_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module met_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hdl/met_update.sv
// Extremum test and per-channel state update for one sample.
`timescale 1ns / 1ps
`default_nettype none

module met_update #(
    parameter int EXTREMA_DEPTH = 128
) (
    input  wire met_pkg::chan_state_t state,
    input  wire logic [31:0]          sample,
    input  wire logic [31:0]          time_tick,
    output met_pkg::chan_state_t      state_next,
    output met_pkg::ext_result_t      result
);

    localparam logic [met_pkg::SLOT_PTR_W-1:0] SLOT_LAST =
        met_pkg::SLOT_PTR_W'(EXTREMA_DEPTH - 1);

    logic                            is_max;
    logic                            is_min;
    logic [31:0]                     cnt;
    logic [47:0]                     sum;
    logic [31:0]                     last;
    logic [met_pkg::SLOT_PTR_W-1:0]  slot;
    logic [31:0]                     interval;
    logic [48:0]                     sum_wide;
    logic [47:0]                     sum_new;
    logic [31:0]                     cnt_new;
    logic [met_pkg::SLOT_PTR_W-1:0]  slot_new;

    // Peak wins over valley; ties are neither
    assign is_max = ($signed(state.prev_sample) > $signed(sample)) &&
                    ($signed(state.prev_sample) > $signed(state.older_sample));
    assign is_min = !is_max &&
                    ($signed(sample) > $signed(state.prev_sample)) &&
                    ($signed(state.older_sample) > $signed(state.prev_sample));

    // Pick the statistics of the kind found
    assign cnt  = is_min ? state.min_count        : state.max_count;
    assign sum  = is_min ? state.min_interval_sum : state.max_interval_sum;
    assign last = is_min ? state.last_min_time    : state.last_max_time;
    assign slot = is_min ? state.min_slot         : state.max_slot;

    // Interval wraps modulo 2^32; sum and count saturate
    assign interval = time_tick - last;
    assign sum_wide = {1'b0, sum} + {17'd0, interval};
    assign sum_new  = sum_wide[48] ? met_pkg::SUM_MAX : sum_wide[47:0];
    assign cnt_new  = (cnt == met_pkg::COUNT_MAX) ? cnt : cnt + 32'd1;

    // Ring pointer tracks count mod depth; frozen once the count saturates
    always_comb
    begin
        if (cnt == met_pkg::COUNT_MAX)
        begin
            slot_new = slot;
        end
        else if (slot == SLOT_LAST)
        begin
            slot_new = '0;
        end
        else
        begin
            slot_new = slot + met_pkg::SLOT_PTR_W'(1);
        end
    end

    // Next state: update the kind found, then shift the history
    always_comb
    begin
        state_next              = state;
        state_next.older_sample = state.prev_sample;
        state_next.prev_sample  = sample;
        if (is_max)
        begin
            state_next.max_count        = cnt_new;
            state_next.max_interval_sum = sum_new;
            state_next.last_max_time    = time_tick;
            state_next.max_slot         = slot_new;
        end
        if (is_min)
        begin
            state_next.min_count        = cnt_new;
            state_next.min_interval_sum = sum_new;
            state_next.last_min_time    = time_tick;
            state_next.min_slot         = slot_new;
        end
    end

    // Result fields, all zero when nothing was found
    always_comb
    begin
        result = '0;
        if (is_max || is_min)
        begin
            result.kind          = is_max ? met_pkg::KIND_MAX : met_pkg::KIND_MIN;
            result.extreme_value = state.prev_sample;
            result.slot_ptr      = slot;
            result.interval      = interval;
            result.kind_count    = cnt_new;
            result.interval_sum  = sum_new;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/multichannel_extremum_tracker_core.sv
// Top level of the multichannel extremum tracker.
// Takes one sample transaction per cycle unless the output is stalled, and
// returns one result transaction per sample through two register stages:
// the sample is registered in the stage-one registers, where it waits while
// the output is stalled, and its result in the output registers. Per-channel
// history and statistics live in a state memory of CHANNELS words with a
// registered read; the read is issued when a sample is accepted, the
// update is computed in the following cycle and written back, and a
// one-entry bypass of the latest write covers back-to-back samples on the
// same channel. Per-channel valid flags make never-written entries read as
// zero, so no clearing pass is needed after reset. Found peaks and valleys
// go to a write-only ring store of 2 * CHANNELS * EXTREMA_DEPTH words.
// Throughput is set by the single state-memory port pair: one sample per
// cycle, sustained, unless the output is stalled. Samples whose channel is
// at or above CHANNELS leave the state untouched and return kind none.
`timescale 1ns / 1ps
`default_nettype none

module multichannel_extremum_tracker_core #(
    parameter int CHANNELS      = 8,
    parameter int EXTREMA_DEPTH = 128
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // sample channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  channel,
    input  wire logic [31:0] sample,
    input  wire logic [31:0] time_tick,
    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       kind,
    output logic [2:0]       channel_out,
    output logic [31:0]      extreme_value,
    output logic [6:0]       slot,
    output logic [31:0]      interval,
    output logic [31:0]      kind_count,
    output logic [47:0]      interval_sum
);

    localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ST_W     = $bits(met_pkg::chan_state_t);
    localparam int RS_DEPTH = 2 * CHANNELS * EXTREMA_DEPTH;
    localparam int RS_AW    = $clog2(RS_DEPTH);

    // Pipeline registers
    logic                 s1_valid_reg;
    logic [2:0]           s1_chan_reg;
    logic [31:0]          s1_sample_reg;
    logic [31:0]          s1_tick_reg;
    logic                 s1_in_range_reg;
    logic                 out_valid_reg;
    logic [2:0]           out_chan_reg;
    met_pkg::ext_result_t out_res_reg;

    // Bypass of the latest state write
    logic                 fwd_valid_reg;
    logic [CH_AW-1:0]     fwd_ch_reg;
    met_pkg::chan_state_t fwd_state_reg;

    logic [CHANNELS-1:0]  entry_valid_reg;
    logic [CHANNELS-1:0]  entry_valid_next;

    logic                 out_free;
    logic                 s1_adv;
    logic                 in_acc;
    logic                 in_range;
    logic [CH_AW-1:0]     in_ch_idx;
    logic [CH_AW-1:0]     s1_ch_idx;
    logic [ST_W-1:0]      st_rdata;
    met_pkg::chan_state_t cur_state;
    met_pkg::chan_state_t new_state;
    met_pkg::ext_result_t res;
    met_pkg::ext_result_t res_gated;
    logic                 st_we;
    logic                 rs_we;
    logic [RS_AW-1:0]     rs_addr;

    // Handshake
    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_adv    = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_acc    = in_valid && !in_stall;
    assign in_range  = 32'(channel) < 32'(CHANNELS);
    assign in_ch_idx = CH_AW'(channel);
    assign s1_ch_idx = CH_AW'(s1_chan_reg);

    // Per-channel state memory
    met_ram #(
        .WIDTH(ST_W),
        .DEPTH(CHANNELS)
    ) u_state_ram (
        .clk  (clk),
        .we   (st_we),
        .waddr(s1_ch_idx),
        .wdata(ST_W'(new_state)),
        .re   (in_acc),
        .raddr(in_ch_idx),
        .rdata(st_rdata)
    );

    // Current state: bypass, then memory, then reset value
    always_comb
    begin
        if (fwd_valid_reg && (fwd_ch_reg == s1_ch_idx))
        begin
            cur_state = fwd_state_reg;
        end
        else if (s1_in_range_reg && entry_valid_reg[s1_ch_idx])
        begin
            cur_state = met_pkg::chan_state_t'(st_rdata);
        end
        else
        begin
            cur_state = '0;
        end
    end

    met_update #(
        .EXTREMA_DEPTH(EXTREMA_DEPTH)
    ) u_update (
        .state     (cur_state),
        .sample    (s1_sample_reg),
        .time_tick (s1_tick_reg),
        .state_next(new_state),
        .result    (res)
    );

    assign res_gated = s1_in_range_reg ? res : '0;
    assign st_we     = s1_adv && s1_in_range_reg;
    assign rs_we     = st_we && (res.kind != met_pkg::KIND_NONE);

    // Ring store address: kind bank, channel row, slot
    always_comb
    begin
        rs_addr = RS_AW'(s1_ch_idx) * RS_AW'(EXTREMA_DEPTH) + RS_AW'(res.slot_ptr);
        if (res.kind == met_pkg::KIND_MIN)
        begin
            rs_addr = rs_addr + RS_AW'(CHANNELS * EXTREMA_DEPTH);
        end
    end

    // Write-only ring store of peaks and valleys
    met_ram #(
        .WIDTH(32),
        .DEPTH(RS_DEPTH)
    ) u_ring_ram (
        .clk  (clk),
        .we   (rs_we),
        .waddr(rs_addr),
        .wdata(res.extreme_value),
        .re   (1'b0),
        .raddr('0),
        .rdata()
    );

    // Valid flags set on first write of a channel
    always_comb
    begin
        entry_valid_next = entry_valid_reg;
        if (st_we)
        begin
            entry_valid_next[s1_ch_idx] = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            fwd_valid_reg   <= 1'b0;
            entry_valid_reg <= '0;
        end
        else
        begin
            entry_valid_reg <= entry_valid_next;
            if (in_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (st_we)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_chan_reg     <= channel;
            s1_sample_reg   <= sample;
            s1_tick_reg     <= time_tick;
            s1_in_range_reg <= in_range;
        end
        if (s1_adv)
        begin
            out_chan_reg <= s1_chan_reg;
            out_res_reg  <= res_gated;
        end
        if (st_we)
        begin
            fwd_ch_reg    <= s1_ch_idx;
            fwd_state_reg <= new_state;
        end
    end

    // Outputs
    assign out_valid     = out_valid_reg;
    assign kind          = out_res_reg.kind;
    assign channel_out   = out_chan_reg;
    assign extreme_value = out_res_reg.extreme_value;
    assign slot          = out_res_reg.slot_ptr[6:0];
    assign interval      = out_res_reg.interval;
    assign kind_count    = out_res_reg.kind_count;
    assign interval_sum  = out_res_reg.interval_sum;

    // A result with no extremum carries zero statistics
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_res_reg.kind == met_pkg::KIND_NONE)) |->
        ((out_res_reg.kind_count == 32'd0) && (out_res_reg.interval_sum == 48'd0)))
    else $error("empty result carries statistics");

    // A found extremum always has a nonzero count after the increment
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_res_reg.kind != met_pkg::KIND_NONE)) |->
        (out_res_reg.kind_count != 32'd0))
    else $error("extremum with zero count");

    // Every state write is captured by the bypass
    assert property (@(posedge clk) disable iff (!rst_n)
        st_we |=> (fwd_valid_reg && (fwd_ch_reg == $past(s1_ch_idx))))
    else $error("bypass missed a state write");

endmodule

`default_nettype wire

FILE: bench/multichannel_extremum_tracker_core_tb.sv
// Self-checking testbench for the multichannel extremum tracker core.
`timescale 1ns / 1ps

module multichannel_extremum_tracker_core_tb;

    localparam int NUM_CHANNELS = 8;
    localparam int RING_DEPTH   = 128;
    localparam int LONG_HOLD    = 300;

    // one sample transaction
    typedef struct packed {
        logic [2:0]  chan;
        logic [31:0] value;
        logic [31:0] tick;
    } sample_txn_t;

    // one result transaction
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  chan;
        logic [31:0] value;
        logic [6:0]  slot;
        logic [31:0] interval;
        logic [31:0] count;
        logic [47:0] sum;
    } extremum_report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  channel = '0;
    logic [31:0] sample = '0;
    logic [31:0] time_tick = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [2:0]  channel_out;
    logic [31:0] extreme_value;
    logic [6:0]  slot;
    logic [31:0] interval;
    logic [31:0] kind_count;
    logic [47:0] interval_sum;

    // predicted per-channel history and statistics
    logic signed [31:0] hist_prev  [NUM_CHANNELS];
    logic signed [31:0] hist_older [NUM_CHANNELS];
    logic [31:0]        peak_count  [NUM_CHANNELS];
    logic [31:0]        valley_count[NUM_CHANNELS];
    logic [47:0]        peak_sum    [NUM_CHANNELS];
    logic [47:0]        valley_sum  [NUM_CHANNELS];
    logic [31:0]        peak_time   [NUM_CHANNELS];
    logic [31:0]        valley_time [NUM_CHANNELS];

    sample_txn_t      pending_samples[$];
    extremum_report_t expected_reports[$];
    sample_txn_t      next_txn;
    extremum_report_t got_report;
    extremum_report_t want_report;

    // stimulus bookkeeping
    logic [31:0] last_queued[NUM_CHANNELS];
    logic [2:0]  last_chan = '0;
    logic [31:0] tick_now = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int holds_done    = 0;
    int hold_left     = 0;
    int errors        = 0;

    multichannel_extremum_tracker_core #(
        .CHANNELS      (NUM_CHANNELS),
        .EXTREMA_DEPTH (RING_DEPTH)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .channel       (channel),
        .sample        (sample),
        .time_tick     (time_tick),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .channel_out   (channel_out),
        .extreme_value (extreme_value),
        .slot          (slot),
        .interval      (interval),
        .kind_count    (kind_count),
        .interval_sum  (interval_sum)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // timeout guard
    initial
    begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // bookkeeping for one peak or valley: slot, interval, saturating sum and count
    function automatic void log_extremum(inout logic [31:0] cnt, inout logic [47:0] sum,
                                         inout logic [31:0] last, input logic [31:0] tick,
                                         inout extremum_report_t r);
        logic [48:0] total;
        r.slot     = 7'(cnt % RING_DEPTH);
        r.interval = tick - last;
        total      = {1'b0, sum} + {17'b0, r.interval};
        sum        = (total > {1'b0, met_pkg::SUM_MAX}) ? met_pkg::SUM_MAX : total[47:0];
        last       = tick;
        if (cnt != met_pkg::COUNT_MAX)
            cnt = cnt + 32'd1;
        r.count = cnt;
        r.sum   = sum;
    endfunction

    // predict the report for one accepted sample and advance the channel history
    function automatic extremum_report_t track_sample(sample_txn_t t);
        extremum_report_t   r;
        logic signed [31:0] p;
        logic signed [31:0] o;
        logic signed [31:0] y;
        r      = '0;
        r.kind = met_pkg::KIND_NONE;
        r.chan = t.chan;
        if (int'(t.chan) < NUM_CHANNELS)
        begin
            p = hist_prev[t.chan];
            o = hist_older[t.chan];
            y = t.value;
            if (p > y && p > o)
            begin
                r.kind  = met_pkg::KIND_MAX;
                r.value = p;
                log_extremum(peak_count[t.chan], peak_sum[t.chan], peak_time[t.chan],
                             t.tick, r);
            end
            else if (y > p && o > p)
            begin
                r.kind  = met_pkg::KIND_MIN;
                r.value = p;
                log_extremum(valley_count[t.chan], valley_sum[t.chan],
                             valley_time[t.chan], t.tick, r);
            end
            hist_older[t.chan] = p;
            hist_prev[t.chan]  = y;
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic [47:0] want, logic [47:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            errors++;
        end
    endfunction

    task automatic queue_sample(logic [2:0] ch, logic [31:0] value, logic [31:0] tick);
        sample_txn_t t;
        t.chan  = ch;
        t.value = value;
        t.tick  = tick;
        pending_samples.push_back(t);
        last_queued[ch] = value;
        last_chan = ch;
    endtask

    // random samples: mixed value shapes, channel bursts, mostly rising time
    task automatic queue_random(int n);
        logic [2:0]  ch;
        logic [31:0] value;
        for (int i = 0; i < n; i++)
        begin
            ch = ($urandom_range(99) < 45) ? last_chan : 3'($urandom_range(NUM_CHANNELS - 1));
            case ($urandom_range(9))
                0, 1, 2: value = $urandom;
                3, 4:    value = 32'($urandom_range(16)) - 32'd8;
                5:       value = last_queued[ch];
                6:
                begin
                    case ($urandom_range(3))
                        0:       value = 32'h7FFF_FFFF;
                        1:       value = 32'h8000_0000;
                        2:       value = 32'h0;
                        default: value = 32'hFFFF_FFFF;
                    endcase
                end
                default: value = last_queued[ch] + 32'($urandom_range(2048)) - 32'd1024;
            endcase
            case ($urandom_range(19))
                0:       tick_now = $urandom;
                1:       tick_now = tick_now - 32'($urandom_range(100));
                default: tick_now = tick_now + 32'($urandom_range(1, 60));
            endcase
            queue_sample(ch, value, tick_now);
        end
    endtask

    // wait until every queued sample is accepted and every report has come back;
    // checked mid-cycle so the clocked processes have settled
    task automatic drain_all();
        while (pending_samples.size() != 0 || in_valid || expected_reports.size() != 0)
            @(negedge clk);
    endtask

    // sample driver
    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
            expected_reports.push_back(track_sample('{channel, sample, time_tick}));
        if (rst_n && (!in_valid || !in_stall))
        begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_txn  = pending_samples.pop_front();
                in_valid  <= 1'b1;
                channel   <= next_txn.chan;
                sample    <= next_txn.value;
                time_tick <= next_txn.tick;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result monitor and output stall generator
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            got_report = '{kind, channel_out, extreme_value, slot, interval, kind_count,
                           interval_sum};
            if (expected_reports.size() == 0)
            begin
                $error("unexpected result transaction: channel %0d kind %0d",
                       channel_out, kind);
                errors++;
            end
            else
            begin
                want_report = expected_reports.pop_front();
                check_field("kind", want_report.kind, got_report.kind);
                check_field("channel_out", want_report.chan, got_report.chan);
                check_field("extreme_value", want_report.value, got_report.value);
                check_field("slot", want_report.slot, got_report.slot);
                check_field("interval", want_report.interval, got_report.interval);
                check_field("kind_count", want_report.count, got_report.count);
                check_field("interval_sum", want_report.sum, got_report.sum);
            end
        end
        // a requested long hold overrides the random stalls
        if (holds_done != hold_requests)
        begin
            holds_done <= holds_done + 1;
            hold_left  <= LONG_HOLD;
            out_stall  <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // stimulus sequence
    initial
    begin
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            hist_prev[c]    = '0;
            hist_older[c]   = '0;
            peak_count[c]   = '0;
            valley_count[c] = '0;
            peak_sum[c]     = '0;
            valley_sum[c]   = '0;
            peak_time[c]    = '0;
            valley_time[c]  = '0;
            last_queued[c]  = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // sender idles more lightly than the receiver
        send_idle_pct = 32;
        recv_idle_pct = 57;

        // full-scale peak then valley, ties, and time running backwards
        queue_sample(3'd0, 32'h7FFF_FFFF, 32'd10);
        queue_sample(3'd0, 32'h8000_0000, 32'd20);
        queue_sample(3'd0, 32'h7FFF_FFFF, 32'd5);
        queue_sample(3'd0, 32'h7FFF_FFFF, 32'd3);
        queue_sample(3'd0, 32'h0000_0000, 32'd2);
        queue_sample(3'd0, 32'h7FFF_FFFF, 32'd1);
        queue_sample(3'd0, 32'h8000_0000, 32'd0);
        // small Q16.16 wave on the top channel, edge tick values
        queue_sample(3'd7, 32'h0001_0000, 32'hFFFF_FFFF);
        queue_sample(3'd7, 32'h0003_0000, 32'h0000_0000);
        queue_sample(3'd7, 32'h0001_8000, 32'hFFFF_FFFF);
        queue_sample(3'd7, 32'hFFFF_0000, 32'h0000_0000);
        queue_sample(3'd7, 32'hFFFF_0000, 32'h8000_0000);
        // interleaved channels, equal neighbors on one side only
        queue_sample(3'd1, 32'hFFFF_FFFF, 32'd100);
        queue_sample(3'd2, 32'h0000_0001, 32'd101);
        queue_sample(3'd1, 32'hFFFF_FFFF, 32'd102);
        queue_sample(3'd2, 32'h0000_0001, 32'd103);
        queue_sample(3'd1, 32'hFFFF_FFFE, 32'd104);
        queue_sample(3'd2, 32'h0000_0000, 32'd105);
        queue_sample(3'd1, 32'h0000_0000, 32'd106);
        queue_sample(3'd2, 32'h0000_0002, 32'd107);
        drain_all();

        queue_random(150);
        drain_all();
        queue_random(150);
        drain_all();

        // sender now idles more than the receiver
        send_idle_pct = 57;
        recv_idle_pct = 32;
        queue_random(300);
        drain_all();

        // no idling; long output hold while the sender keeps offering
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests = hold_requests + 1;
        queue_random(150);
        drain_all();
        queue_random(150);
        drain_all();

        repeat (20) @(posedge clk);
        if (expected_reports.size() != 0)
        begin
            $error("%0d result transactions never arrived", expected_reports.size());
            errors++;
        end
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sim.f
hdl/met_pkg.sv
hdl/met_ram.sv
hdl/met_update.sv
hdl/multichannel_extremum_tracker_core.sv
bench/multichannel_extremum_tracker_core_tb.sv
